// File: src/idalloc_pkg.sv
`default_nettype none

package idalloc_pkg;

   // ID space and derived widths
   localparam int CAPACITY = 1024;
   localparam int ID_W     = 10;
   localparam int CNT_W    = ID_W + 1;

   // live bitmap is stored as rows of ROW_W bits
   localparam int ROW_W  = 32;
   localparam int ROWS   = CAPACITY / ROW_W;
   localparam int ROW_AW = $clog2(ROWS);
   localparam int BIT_AW = $clog2(ROW_W);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_LIVE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic map_rd_cand;
      logic fifo_rd;
      logic map_rd_pop;
      logic map_update;
      logic set_full;
      logic load_rsp;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_free;
      logic fifo_empty;
      logic full;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: src/idalloc_ifs.sv
`default_nettype none

interface idalloc_req_if import idalloc_pkg::*;;
   logic            valid;
   logic            ready;
   logic            op;
   logic [ID_W-1:0] id_in;

   modport source (output valid, output op, output id_in, input ready);
   modport sink   (input valid, input op, input id_in, output ready);
endinterface

interface idalloc_rsp_if import idalloc_pkg::*;;
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] id_out;
   logic [1:0]      status;

   modport source (output valid, output id_out, output status, input ready);
   modport sink   (input valid, input id_out, input status, output ready);
endinterface

`default_nettype wire

// File: src/id_allocator_free_fifo.sv
// Steps: a free or a fresh allocate passes decide, update and done; an
//   allocate that pops a freed id adds a pop; a full one skips the update.
// One request beat is handled at a time, paced by the read-modify-write of
//   a live bitmap row through the registered RAM port.
// Reset: synchronous; clears counts, FIFO pointers and the 32 row-valid bits
//   of the live map at once. No clearing pass: the block is ready right away.
`default_nettype none

module id_allocator_free_fifo import idalloc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   idalloc_req_if.sink   req_chan,
   idalloc_rsp_if.source rsp_chan
);

   // Controller sequences one beat at a time:
   //   idle -> decide -> (pop) -> update -> done, or decide -> done if full
   // The datapath keeps the live bitmap (rows in RAM, valid bit per row),
   // the free-id FIFO RAM with its pointers, and the result register.
   // The result register decouples the two sides: a new request beat is
   // taken while a finished result still waits for the consumer.

   dp_cmd_type    cmd;
   dp_status_type stat;
   logic          ready;

   idalloc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   // hold the request payload in the datapath on accept; drive the
   // result channel straight from its output register
   idalloc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_op    (req_chan.op),
      .req_id_in (req_chan.id_in),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_id_out(rsp_chan.id_out),
      .rsp_status(rsp_chan.status)
   );

   assign req_chan.ready = ready;

endmodule

`default_nettype wire

// File: src/idalloc_ram.sv
`default_nettype none

module idalloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/idalloc_ctrl.sv
`default_nettype none

module idalloc_ctrl import idalloc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type stat,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_POP,
      S_UPDATE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_free || (stat.fifo_empty && !stat.full)) begin
               cmd.map_rd_cand = 1'b1;
               state_in        = S_UPDATE;
            end else if (!stat.fifo_empty) begin
               cmd.fifo_rd = 1'b1;
               state_in    = S_POP;
            end else begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_POP: begin
            cmd.map_rd_pop = 1'b1;
            state_in       = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.map_update = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/idalloc_dp.sv
`default_nettype none

module idalloc_dp import idalloc_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire dp_cmd_type      cmd,
   output dp_status_type        stat,
   input  wire logic            req_op,
   input  wire logic [ID_W-1:0] req_id_in,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic      [ID_W-1:0] rsp_id_out,
   output logic      [1:0]      rsp_status
);

   logic              op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [ID_W-1:0]   work_id_ff;
   logic [1:0]        status_ff;
   logic [CNT_W-1:0]  live_count_ff;
   logic [ID_W-1:0]   head_ff;
   logic [ID_W-1:0]   tail_ff;
   logic [CNT_W-1:0]  fifo_count_ff;
   logic [ROWS-1:0]   row_valid_ff;
   logic              rd_row_valid_ff;
   logic              rsp_valid_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [1:0]        rsp_status_ff;

   logic [ID_W-1:0]   cand_id;
   logic [ID_W-1:0]   fifo_rdata;
   logic [ROW_W-1:0]  map_rdata;
   logic [ROW_AW-1:0] map_rd_addr;
   logic              map_rd_en;
   logic [ROW_W-1:0]  cur_row;
   logic [ROW_W-1:0]  bit_mask;
   logic              cur_bit;
   logic [ROW_W-1:0]  new_row;
   logic              map_wr_en;
   logic              push_en;
   logic              fifo_full;

   // fresh id is the live count; free names the latched id
   assign cand_id = (op_ff == OP_FREE) ? id_ff : live_count_ff[ID_W-1:0];

   assign map_rd_en   = cmd.map_rd_cand | cmd.map_rd_pop;
   assign map_rd_addr = cmd.map_rd_pop ? fifo_rdata[ID_W-1:BIT_AW]
                                       : cand_id[ID_W-1:BIT_AW];

   // a row never written reads as all clear
   assign cur_row  = rd_row_valid_ff ? map_rdata : '0;
   assign bit_mask = ROW_W'(1) << work_id_ff[BIT_AW-1:0];
   assign cur_bit  = |(cur_row & bit_mask);
   assign new_row  = (op_ff == OP_FREE) ? (cur_row & ~bit_mask) : (cur_row | bit_mask);

   assign fifo_full = (fifo_count_ff == CNT_W'(CAPACITY));
   assign map_wr_en = cmd.map_update && ((op_ff == OP_ALLOC) || cur_bit);
   assign push_en   = cmd.map_update && (op_ff == OP_FREE) && cur_bit && !fifo_full;

   idalloc_ram #(
      .WIDTH(ROW_W),
      .DEPTH(ROWS)
   ) u_live_map (
      .clock  (clock),
      .wr_en  (map_wr_en),
      .wr_addr(work_id_ff[ID_W-1:BIT_AW]),
      .wr_data(new_row),
      .rd_en  (map_rd_en),
      .rd_addr(map_rd_addr),
      .rd_data(map_rdata)
   );

   idalloc_ram #(
      .WIDTH(ID_W),
      .DEPTH(CAPACITY)
   ) u_free_fifo (
      .clock  (clock),
      .wr_en  (push_en),
      .wr_addr(tail_ff),
      .wr_data(work_id_ff),
      .rd_en  (cmd.fifo_rd),
      .rd_addr(head_ff),
      .rd_data(fifo_rdata)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         live_count_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fifo_count_ff <= '0;
         row_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.fifo_rd) begin
            head_ff       <= (head_ff == ID_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
            fifo_count_ff <= fifo_count_ff - 1'b1;
         end
         if (push_en) begin
            tail_ff       <= (tail_ff == ID_W'(CAPACITY - 1)) ? '0 : tail_ff + 1'b1;
            fifo_count_ff <= fifo_count_ff + 1'b1;
         end
         if (map_wr_en) begin
            row_valid_ff[work_id_ff[ID_W-1:BIT_AW]] <= 1'b1;
            if (op_ff == OP_FREE) begin
               live_count_ff <= live_count_ff - 1'b1;
            end else if (!cur_bit) begin
               live_count_ff <= live_count_ff + 1'b1;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_op;
         id_ff <= req_id_in;
      end
      if (map_rd_en) begin
         rd_row_valid_ff <= row_valid_ff[map_rd_addr];
      end
      if (cmd.map_rd_cand) begin
         work_id_ff <= cand_id;
      end else if (cmd.map_rd_pop) begin
         work_id_ff <= fifo_rdata;
      end else if (cmd.set_full) begin
         work_id_ff <= '0;
      end
      if (cmd.set_full) begin
         status_ff <= ST_FULL;
      end else if (cmd.map_update) begin
         status_ff <= ((op_ff == OP_FREE) && !cur_bit) ? ST_NOT_LIVE : ST_OK;
      end
      if (cmd.load_rsp) begin
         rsp_id_ff     <= work_id_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign stat.is_free    = (op_ff == OP_FREE);
   assign stat.fifo_empty = (fifo_count_ff == '0);
   assign stat.full       = (live_count_ff == CNT_W'(CAPACITY));
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_id_out = rsp_id_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

// File: src/idalloc_checker.sv
`default_nettype none

module idalloc_checker import idalloc_pkg::*; (
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire logic [ID_W-1:0] rsp_id_out,
   input wire logic [1:0]      rsp_status
);

   // one beat at a time: drop ready right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   a_full_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_id_out == '0))
      else $error("full result carries nonzero id");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_id_out) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind id_allocator_free_fifo idalloc_checker u_idalloc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_id_out(rsp_chan.id_out),
   .rsp_status(rsp_chan.status)
);

`default_nettype wire

// File: tb/sv/tb_id_allocator_free_fifo.sv
`timescale 1ns / 100ps

module tb_id_allocator_free_fifo;
   import idalloc_pkg::*;

   // Waits drawn per beat on either side are at most WAIT_MAX.
   localparam int WAIT_MAX       = 15;
   // One long receiver hold-off, long enough to back the block up into the sender.
   localparam int HOLDOFF_CYCLES = 300;
   // Cycles without any beat on either channel before the run is declared hung.
   // Covers the hold-off above plus the worst gap, stall and pop latency.
   localparam int WATCHDOG_LIMIT = 2000;
   // Quiet cycles after the last expected result, to catch stray beats.
   localparam int TAIL_CYCLES    = 20;
   localparam int NUM_DIRECTED   = 21;
   localparam int NUM_PHASES     = 11;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [1:0]      status;
   } alloc_result_type;

   // One row of the directed table. When hand_checked is set, the result
   // below is pushed as the expectation instead of the prediction.
   typedef struct packed {
      logic             op;
      logic [ID_W-1:0]  id;
      bit               hand_checked;
      alloc_result_type result;
   } directed_row_type;

   // One stretch of random traffic: share of allocates, share of frees of
   // arbitrary ids (mostly not live), length, and whether both sides run
   // back to back without waits.
   typedef struct packed {
      int unsigned alloc_pct;
      int unsigned noise_pct;
      int unsigned beats;
      bit          burst;
   } load_phase_type;

   logic clock = 1'b0;
   logic reset;

   idalloc_req_if req_chan ();
   idalloc_rsp_if rsp_chan ();

   id_allocator_free_fifo u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   wire req_fire = req_chan.valid && req_chan.ready;
   wire rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // ------------------------------------------------------------------
   // Shadow of the allocator: live bitmap, live count and the ring of
   // freed ids. Advanced once per accepted request beat.
   // ------------------------------------------------------------------
   bit              id_live [CAPACITY];
   logic [ID_W-1:0] freed_ids [CAPACITY];
   int unsigned     live_total  = 0;
   int unsigned     freed_head  = 0;
   int unsigned     freed_tail  = 0;
   int unsigned     freed_total = 0;

   alloc_result_type awaited_results [$];
   int unsigned      mismatches      = 0;
   int unsigned      quiet_cycles    = 0;
   bit               burst_mode      = 1'b0;
   bit               holdoff_pending = 1'b0;

   directed_row_type directed_rows [NUM_DIRECTED];
   load_phase_type   load_phases [NUM_PHASES];

   function automatic int unsigned ring_step(int unsigned ptr);
      return (ptr + 1 >= CAPACITY) ? 0 : ptr + 1;
   endfunction

   // Apply one request to the shadow state and return the result it yields.
   function automatic alloc_result_type predict_alloc_result(logic op, logic [ID_W-1:0] id);
      alloc_result_type res;
      res.id     = '0;
      res.status = ST_OK;
      if (op == OP_ALLOC) begin
         if (freed_total > 0) begin
            // reuse the oldest freed id first
            res.id      = freed_ids[freed_head];
            freed_head  = ring_step(freed_head);
            freed_total = freed_total - 1;
            if (!id_live[res.id]) begin
               id_live[res.id] = 1'b1;
               live_total      = live_total + 1;
            end
         end else if (live_total < CAPACITY) begin
            // no freed id waiting: hand out the live count as a fresh id
            res.id = ID_W'(live_total);
            if (!id_live[res.id]) begin
               id_live[res.id] = 1'b1;
               live_total      = live_total + 1;
            end
         end else begin
            res.status = ST_FULL;
         end
      end else begin
         res.id = id;
         if (id_live[id]) begin
            id_live[id] = 1'b0;
            live_total  = live_total - 1;
            if (freed_total < CAPACITY) begin
               freed_ids[freed_tail] = id;
               freed_tail            = ring_step(freed_tail);
               freed_total           = freed_total + 1;
            end
         end else begin
            res.status = ST_NOT_LIVE;
         end
      end
      return res;
   endfunction

   // Pick a live id from a random starting point, so frees hit scattered ids.
   function automatic logic [ID_W-1:0] pick_live_id();
      int unsigned     start;
      logic [ID_W-1:0] probe;
      start = $urandom_range(CAPACITY - 1);
      for (int k = 0; k < CAPACITY; k++) begin
         probe = ID_W'((start + k) % CAPACITY);
         if (id_live[probe]) return probe;
      end
      return ID_W'(start);
   endfunction

   function automatic int unsigned draw_wait();
      return burst_mode ? 0 : $urandom_range(WAIT_MAX);
   endfunction

   // Offer one request beat after a random gap; on acceptance, advance the
   // shadow and queue the expected result. Returns at the accepting edge
   // without touching valid, so the next beat can follow with no bubble.
   task automatic send_beat(input logic op, input logic [ID_W-1:0] id,
                            input bit hand_checked, input alloc_result_type hand_result);
      int unsigned      gap;
      alloc_result_type predicted;
      gap = draw_wait();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.id_in <= id;
      do @(posedge clock); while (!req_chan.ready);
      predicted = predict_alloc_result(op, id);
      awaited_results.push_back(hand_checked ? hand_result : predicted);
   endtask

   // Drop valid and hold until every outstanding result has come back.
   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int unsigned     roll;
      logic [ID_W-1:0] rand_id;
      load_phase_type  phase;

      req_chan.valid <= 1'b0;
      req_chan.op    <= OP_ALLOC;
      req_chan.id_in <= '0;
      reset          <= 1'b1;

      // Rows with a hand-written result follow directly from an empty allocator;
      // the rest are left to the shadow model.
      directed_rows = '{
         '{OP_ALLOC, 10'd0,    1'b1, '{10'd0,    ST_OK}},       // first fresh id
         '{OP_ALLOC, 10'd1023, 1'b1, '{10'd1,    ST_OK}},       // id_in ignored
         '{OP_ALLOC, 10'd0,    1'b1, '{10'd2,    ST_OK}},
         '{OP_FREE,  10'd1023, 1'b1, '{10'd1023, ST_NOT_LIVE}}, // top id, never live
         '{OP_FREE,  10'd0,    1'b1, '{10'd0,    ST_OK}},
         '{OP_FREE,  10'd0,    1'b1, '{10'd0,    ST_NOT_LIVE}}, // double free
         '{OP_FREE,  10'd2,    1'b1, '{10'd2,    ST_OK}},
         '{OP_ALLOC, 10'd0,    1'b1, '{10'd0,    ST_OK}},       // oldest freed first
         '{OP_ALLOC, 10'd0,    1'b1, '{10'd2,    ST_OK}},
         '{OP_ALLOC, 10'd0,    1'b1, '{10'd3,    ST_OK}},       // ring empty: fresh
         '{OP_FREE,  10'd1,    1'b0, '{10'd0,    ST_OK}},
         '{OP_FREE,  10'd3,    1'b0, '{10'd0,    ST_OK}},
         '{OP_FREE,  10'd0,    1'b0, '{10'd0,    ST_OK}},
         '{OP_ALLOC, 10'd0,    1'b0, '{10'd0,    ST_OK}},
         '{OP_FREE,  10'h2AA,  1'b0, '{10'd0,    ST_OK}},
         '{OP_FREE,  10'h155,  1'b0, '{10'd0,    ST_OK}},
         '{OP_ALLOC, 10'd0,    1'b0, '{10'd0,    ST_OK}},
         '{OP_ALLOC, 10'd0,    1'b0, '{10'd0,    ST_OK}},
         '{OP_ALLOC, 10'd0,    1'b0, '{10'd0,    ST_OK}},
         '{OP_FREE,  10'd2,    1'b0, '{10'd0,    ST_OK}},
         '{OP_ALLOC, 10'h3FF,  1'b0, '{10'd0,    ST_OK}}
      };

      // Fill about a quarter of the id space, free most of it back into the
      // ring, refill by popping the ring, then mixed traffic at several loads.
      load_phases = '{
         '{100, 0,  250, 1'b1},
         '{0,   0,  150, 1'b1},
         '{100, 0,  120, 1'b1},
         '{20,  10, 25,  1'b0},
         '{50,  10, 25,  1'b1},
         '{80,  10, 25,  1'b0},
         '{50,  15, 25,  1'b0},
         '{5,   10, 25,  1'b0},
         '{95,  10, 25,  1'b0},
         '{50,  10, 25,  1'b1},
         '{35,  10, 25,  1'b0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].op, directed_rows[i].id,
                   directed_rows[i].hand_checked, directed_rows[i].result);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // let the allocator go idle between phases
         pause_until_drained();
         phase      = load_phases[p];
         burst_mode = phase.burst;
         // during the fill, stall the receiver long enough to back up the input
         if (p == 0) holdoff_pending = 1'b1;
         for (int b = 0; b < phase.beats; b++) begin
            roll    = $urandom_range(99);
            rand_id = ID_W'($urandom);
            if (roll < phase.noise_pct) begin
               send_beat(OP_FREE, rand_id, 1'b0, '0);
            end else if ($urandom_range(99) < phase.alloc_pct || live_total == 0) begin
               send_beat(OP_ALLOC, rand_id, 1'b0, '0);
            end else begin
               send_beat(OP_FREE, pick_live_id(), 1'b0, '0);
            end
         end
      end

      pause_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: draw a stall per result beat, or take the one long
   // hold-off when the stimulus asks for it.
   // ------------------------------------------------------------------
   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holdoff_pending) begin
            stall           = HOLDOFF_CYCLES;
            holdoff_pending = 1'b0;
         end else begin
            stall = draw_wait();
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // ------------------------------------------------------------------
   // Checker: compare each result beat with the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_fire) begin
         if (awaited_results.size() == 0) begin
            mismatches = mismatches + 1;
            $error("result beat with nothing outstanding: id_out %0d status %0d",
                   rsp_chan.id_out, rsp_chan.status);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_chan.id_out !== want.id) begin
               mismatches = mismatches + 1;
               $error("id_out mismatch: expected %0d, actual %0d",
                      want.id, rsp_chan.id_out);
            end
            if (rsp_chan.status !== want.status) begin
               mismatches = mismatches + 1;
               $error("status mismatch: expected %0d, actual %0d",
                      want.status, rsp_chan.status);
            end
         end
      end
   end

   // Watchdog: abort when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
